// ----- rtl/rms_current_dc_blocked_unit_defines.svh -----
// Assertion macros used by the checker file of the RMS current unit.
`ifndef RMS_CURRENT_DC_BLOCKED_UNIT_DEFINES_SVH
`define RMS_CURRENT_DC_BLOCKED_UNIT_DEFINES_SVH

// Same-cycle implication, switched off while reset is asserted.
`define RCDB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rcdb: same-cycle check failed");

// Next-cycle implication, switched off while reset is asserted.
`define RCDB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rcdb: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define RCDB_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("rcdb: reset check failed");

`endif

// ----- rtl/rcdb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rcdb_pkg;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_FILTER_COEFF  = 2'd0;
    localparam t_cfg_idx CFG_WINDOW_LENGTH = 2'd1;
    localparam t_cfg_idx CFG_CURRENT_GAIN  = 2'd2;
    localparam t_cfg_idx CFG_LINE_VOLTAGE  = 2'd3;

    // Register widths and reset values.
    localparam int COEFF_W = 16;
    localparam int WLEN_W  = 16;
    localparam int GAIN_W  = 32;
    localparam int VOLT_W  = 10;

    localparam logic [COEFF_W-1:0] COEFF_RESET = 16'd65274;
    localparam logic [WLEN_W-1:0]  WLEN_RESET  = 16'd1024;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 32'd35553;
    localparam logic [VOLT_W-1:0]  VOLT_RESET  = 10'd220;

    // Result widths.
    localparam int RMS_W   = 32;
    localparam int POWER_W = 48;

    // Shared shift-add multiplier: multiplicand and multiplier widths.
    localparam int MC_W = 40;
    localparam int MP_W = 32;

    // Divider and square root unit.
    localparam int SUM_W  = 64;
    localparam int ROOT_W = 32;
    localparam int REM_W  = 35;

    // Request from the sequencer to the divide and root unit.
    typedef struct packed {
        logic start;
        logic sqrt_mode;
    } t_dsq_ctl;

endpackage

`default_nettype wire

// ----- rtl/rcdb_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rcdb_mul (
    input  wire                                          i_clk,
    input  wire                                          i_rst_n,
    input  wire                                          i_start,
    input  wire  [rcdb_pkg::MC_W-1:0]                    i_mcand,
    input  wire  [rcdb_pkg::MP_W-1:0]                    i_mplier,
    output logic                                         o_done,
    output logic [rcdb_pkg::MC_W+rcdb_pkg::MP_W-1:0]     o_prod
);

    localparam int MCW   = rcdb_pkg::MC_W;
    localparam int MPW   = rcdb_pkg::MP_W;
    localparam int CNT_W = $clog2(MPW + 1);

    logic [MCW-1:0]   r_mcand;
    logic [MCW-1:0]   r_hi;
    logic [MPW-1:0]   r_lo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [MCW:0]     w_sum;

    // One multiplier bit per cycle: add the multiplicand into the upper half, shift right.
    assign w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_mcand <= i_mcand;
                r_hi    <= '0;
                r_lo    <= i_mplier;
                r_cnt   <= CNT_W'(MPW);
                r_busy  <= 1'b1;
            end else if (r_busy) begin
                r_hi  <= w_sum[MCW:1];
                r_lo  <= {w_sum[0], r_lo[MPW-1:1]};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};

endmodule

`default_nettype wire

// ----- rtl/rcdb_dsq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rcdb_dsq #(
    parameter int DIV_W = 17
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire  rcdb_pkg::t_dsq_ctl       i_ctl,
    input  wire  [rcdb_pkg::SUM_W-1:0]     i_operand,
    input  wire  [DIV_W-1:0]               i_divisor,
    output logic                           o_done,
    output logic [rcdb_pkg::SUM_W-1:0]     o_result
);

    localparam int SW    = rcdb_pkg::SUM_W;
    localparam int RW    = rcdb_pkg::REM_W;
    localparam int TW    = rcdb_pkg::ROOT_W;
    localparam int CNT_W = $clog2(SW + 1);

    logic [SW-1:0]    r_val;
    logic [RW-1:0]    r_rem;
    logic [TW-1:0]    r_root;
    logic [DIV_W-1:0] r_div;
    logic             r_sqrt;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [RW-1:0]    w_rem_sh;
    logic [RW-1:0]    w_trial;
    logic [RW:0]      w_diff;
    logic             w_ge;

    // Division brings in one dividend bit per step, the root two radicand bits.
    // Both share one trial subtraction.
    always_comb begin
        if (r_sqrt) begin
            w_rem_sh = {r_rem[RW-3:0], r_val[SW-1:SW-2]};
            w_trial  = RW'({r_root, 2'b01});
        end else begin
            w_rem_sh = {r_rem[RW-2:0], r_val[SW-1]};
            w_trial  = RW'(r_div);
        end
        w_diff = {1'b0, w_rem_sh} - {1'b0, w_trial};
        w_ge   = !w_diff[RW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_val  <= i_operand;
                r_rem  <= '0;
                r_root <= '0;
                r_div  <= i_divisor;
                r_sqrt <= i_ctl.sqrt_mode;
                r_cnt  <= i_ctl.sqrt_mode ? CNT_W'(SW / 2) : CNT_W'(SW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[RW-1:0] : w_rem_sh;
                if (r_sqrt) begin
                    r_val  <= {r_val[SW-3:0], 2'b00};
                    r_root <= {r_root[TW-2:0], w_ge};
                end else begin
                    r_val <= {r_val[SW-2:0], w_ge};
                end
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_sqrt ? SW'(r_root) : r_val;

endmodule

`default_nettype wire

// ----- rtl/rms_current_dc_blocked_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// RMS current meter with a DC-blocking high-pass in front of the squarer.
// Input channel: i_valid / o_stall carry one request of i_sample and i_read_failed.
// Output channel: o_valid / i_stall carry o_rms_current, o_power and o_status.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index at once.
// Work: a sample that does not close the window makes two 32-step passes of the
// shared shift-add multiplier (filter coefficient, then square). A window-closing
// sample adds a 64-step divider pass, a 32-step square root pass and two more
// multiplier passes (gain, then power); the block returns to idle as its result
// enters the output register. A failed read goes straight to the emit step.
// Only one request is in work at a time; o_stall is high while it is.
// The output register holds a result while i_stall is high and a finished
// request waits in its last step until that register is free.
// Reset clears the filter, the sum and the count, restores the register
// defaults and drops any pending result.
module rms_current_dc_blocked_unit #(
    parameter int ADC_BITS   = 10,
    parameter int COUNT_BITS = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    output logic                                o_stall,
    input  wire  [ADC_BITS-1:0]                 i_sample,
    input  wire                                 i_read_failed,
    output logic                                o_valid,
    input  wire                                 i_stall,
    output logic [rcdb_pkg::RMS_W-1:0]          o_rms_current,
    output logic [rcdb_pkg::POWER_W-1:0]        o_power,
    output logic                                o_status,
    input  wire                                 i_cfg_we,
    input  wire  [rcdb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [rcdb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int FW    = ADC_BITS + 10;
    localparam int TM_W  = ADC_BITS + 11;
    localparam int PM_W  = TM_W + rcdb_pkg::COEFF_W;
    localparam int RND_W = PM_W - 15;
    localparam int N_W   = COUNT_BITS + 1;
    localparam int CMP_W = (N_W > rcdb_pkg::WLEN_W) ? N_W : rcdb_pkg::WLEN_W;
    localparam int MCW   = rcdb_pkg::MC_W;
    localparam int MPW   = rcdb_pkg::MP_W;
    localparam int SW    = rcdb_pkg::SUM_W;
    localparam int TW    = rcdb_pkg::ROOT_W;
    localparam int RMW   = rcdb_pkg::RMS_W;
    localparam int PWW   = rcdb_pkg::POWER_W;

    localparam logic [RND_W-1:0] RND_LIM  = RND_W'(1) << (FW - 1);
    localparam logic [FW-1:0]    FILT_MAX = {1'b0, {(FW-1){1'b1}}};
    localparam logic [FW-1:0]    FILT_MIN = {1'b1, {(FW-1){1'b0}}};

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FILT  = 4'd1;
    localparam logic [3:0] S_SQGO  = 4'd2;
    localparam logic [3:0] S_SQ    = 4'd3;
    localparam logic [3:0] S_DIVGO = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_SQRT  = 4'd6;
    localparam logic [3:0] S_GAIN  = 4'd7;
    localparam logic [3:0] S_PWR   = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;

    logic [3:0]                     r_state;
    logic [rcdb_pkg::COEFF_W-1:0]   r_coeff;
    logic [rcdb_pkg::WLEN_W-1:0]    r_wlen;
    logic [rcdb_pkg::GAIN_W-1:0]    r_gain;
    logic [rcdb_pkg::VOLT_W-1:0]    r_volt;
    logic [ADC_BITS-1:0]            r_prev;
    logic [ADC_BITS-1:0]            r_x;
    logic [FW-1:0]                  r_filt;
    logic                           r_tneg;
    logic [SW-1:0]                  r_sum;
    logic [COUNT_BITS-1:0]          r_count;
    logic [N_W-1:0]                 r_n;
    logic                           r_big;
    logic [RMW-1:0]                 r_cur;
    logic [PWW-1:0]                 r_pw;
    logic                           r_stat;
    logic                           r_ovalid;
    logic [RMW-1:0]                 r_o_rms;
    logic [PWW-1:0]                 r_o_power;
    logic                           r_o_status;

    logic                           w_accept;
    logic [ADC_BITS:0]              w_d;
    logic [TM_W-1:0]                w_t;
    logic [TM_W-1:0]                w_tmag;
    logic [RND_W-1:0]               w_rnd;
    logic [FW-1:0]                  w_y;
    logic [FW-1:0]                  w_ymag;
    logic [SW:0]                    w_sum_add;
    logic [SW-1:0]                  w_satsum;
    logic [N_W-1:0]                 w_n;
    logic [rcdb_pkg::WLEN_W-1:0]    w_wlen_eff;
    logic                           w_win_end;
    logic                           w_big;
    logic [SW-1:0]                  w_radicand;
    logic [MCW-1:0]                 w_rms;
    logic [RMW-1:0]                 w_cur;

    logic                           w_mul_start;
    logic [MCW-1:0]                 w_mcand;
    logic [MPW-1:0]                 w_mplier;
    logic                           w_mul_done;
    logic [MCW+MPW-1:0]             w_prod;

    rcdb_pkg::t_dsq_ctl             w_dsq_ctl;
    logic [SW-1:0]                  w_dsq_operand;
    logic                           w_dsq_done;
    logic [SW-1:0]                  w_dsq_result;

    assign w_accept = (r_state == S_IDLE) && i_valid;
    assign o_stall  = (r_state != S_IDLE);

    // Filter input: t = y_prev + (x - x_prev) * 256, then its magnitude.
    always_comb begin
        w_d    = {1'b0, i_sample} - {1'b0, r_prev};
        w_t    = {r_filt[FW-1], r_filt} + {{2{w_d[ADC_BITS]}}, w_d, 8'h00};
        w_tmag = w_t[TM_W-1] ? (~w_t + TM_W'(1)) : w_t;
    end

    // Filter output: round half away from zero, drop 16 fraction bits, saturate.
    always_comb begin
        w_rnd = RND_W'(({1'b0, w_prod[PM_W-1:0]} + (PM_W+1)'(32768)) >> 16);
        if (r_tneg) begin
            w_y = (w_rnd > RND_LIM) ? FILT_MIN : (~w_rnd[FW-1:0] + FW'(1));
        end else begin
            w_y = (w_rnd >= RND_LIM) ? FILT_MAX : w_rnd[FW-1:0];
        end
        w_ymag = r_filt[FW-1] ? (~r_filt + FW'(1)) : r_filt;
    end

    // Square accumulation and window bookkeeping.
    always_comb begin
        w_sum_add  = {1'b0, r_sum} + (SW+1)'(w_prod[2*FW-1:0]);
        w_satsum   = w_sum_add[SW] ? {SW{1'b1}} : w_sum_add[SW-1:0];
        w_n        = {1'b0, r_count} + N_W'(1);
        w_wlen_eff = (r_wlen == '0) ? rcdb_pkg::WLEN_W'(1) : r_wlen;
        w_win_end  = (CMP_W'(w_n) >= CMP_W'(w_wlen_eff)) || w_n[COUNT_BITS];
    end

    // Window-end arithmetic between the unit passes.
    always_comb begin
        w_big      = (w_dsq_result[SW-1:48] != '0);
        w_radicand = w_big ? w_dsq_result : {w_dsq_result[47:0], 16'h0000};
        w_rms      = r_big ? {w_dsq_result[TW-1:0], 8'h00} : MCW'(w_dsq_result[TW-1:0]);
        w_cur      = (w_prod[MCW+MPW-1:48] != '0) ? {RMW{1'b1}} : w_prod[47:16];
    end

    // Requests to the shared multiplier.
    always_comb begin
        w_mul_start = 1'b0;
        w_mcand     = '0;
        w_mplier    = '0;
        unique case (r_state)
            S_IDLE: begin
                w_mul_start = w_accept && !i_read_failed;
                w_mcand     = MCW'(w_tmag);
                w_mplier    = MPW'(r_coeff);
            end
            S_SQGO: begin
                w_mul_start = 1'b1;
                w_mcand     = MCW'(w_ymag);
                w_mplier    = MPW'(w_ymag);
            end
            S_SQRT: begin
                w_mul_start = w_dsq_done;
                w_mcand     = w_rms;
                w_mplier    = r_gain;
            end
            S_GAIN: begin
                w_mul_start = w_mul_done;
                w_mcand     = MCW'(w_cur);
                w_mplier    = MPW'(r_volt);
            end
            default: begin
                w_mul_start = 1'b0;
            end
        endcase
    end

    // Requests to the divide and root unit.
    always_comb begin
        w_dsq_ctl     = '0;
        w_dsq_operand = r_sum;
        unique case (r_state)
            S_DIVGO: begin
                w_dsq_ctl.start = 1'b1;
            end
            S_DIV: begin
                w_dsq_ctl.start     = w_dsq_done;
                w_dsq_ctl.sqrt_mode = 1'b1;
                w_dsq_operand       = w_radicand;
            end
            default: begin
                w_dsq_ctl = '0;
            end
        endcase
    end

    rcdb_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_mcand  (w_mcand),
        .i_mplier (w_mplier),
        .o_done   (w_mul_done),
        .o_prod   (w_prod)
    );

    rcdb_dsq #(
        .DIV_W (N_W)
    ) u_dsq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_dsq_ctl),
        .i_operand (w_dsq_operand),
        .i_divisor (r_n),
        .o_done    (w_dsq_done),
        .o_result  (w_dsq_result)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff <= rcdb_pkg::COEFF_RESET;
            r_wlen  <= rcdb_pkg::WLEN_RESET;
            r_gain  <= rcdb_pkg::GAIN_RESET;
            r_volt  <= rcdb_pkg::VOLT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rcdb_pkg::CFG_FILTER_COEFF:  r_coeff <= i_cfg_data[rcdb_pkg::COEFF_W-1:0];
                rcdb_pkg::CFG_WINDOW_LENGTH: r_wlen  <= i_cfg_data[rcdb_pkg::WLEN_W-1:0];
                rcdb_pkg::CFG_CURRENT_GAIN:  r_gain  <= i_cfg_data[rcdb_pkg::GAIN_W-1:0];
                rcdb_pkg::CFG_LINE_VOLTAGE:  r_volt  <= i_cfg_data[rcdb_pkg::VOLT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer, filter state, window state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_prev   <= '0;
            r_filt   <= '0;
            r_sum    <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // The emit step owns the valid flag while it runs.
            if (r_ovalid && !i_stall && (r_state != S_EMIT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_read_failed) begin
                            r_sum   <= '0;
                            r_count <= '0;
                            r_cur   <= '0;
                            r_pw    <= '0;
                            r_stat  <= 1'b1;
                            r_state <= S_EMIT;
                        end else begin
                            r_x     <= i_sample;
                            r_tneg  <= w_t[TM_W-1];
                            r_state <= S_FILT;
                        end
                    end
                end
                S_FILT: begin
                    if (w_mul_done) begin
                        r_filt  <= w_y;
                        r_prev  <= r_x;
                        r_state <= S_SQGO;
                    end
                end
                S_SQGO: begin
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    if (w_mul_done) begin
                        r_sum <= w_satsum;
                        if (w_win_end) begin
                            r_n     <= w_n;
                            r_count <= '0;
                            r_state <= S_DIVGO;
                        end else begin
                            r_count <= w_n[COUNT_BITS-1:0];
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_DIVGO: begin
                    // The divider has taken the sum at this edge.
                    r_sum   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_dsq_done) begin
                        r_big   <= w_big;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (w_dsq_done) begin
                        r_state <= S_GAIN;
                    end
                end
                S_GAIN: begin
                    if (w_mul_done) begin
                        r_cur   <= w_cur;
                        r_state <= S_PWR;
                    end
                end
                S_PWR: begin
                    if (w_mul_done) begin
                        r_pw    <= w_prod[PWW-1:0];
                        r_stat  <= 1'b0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid   <= 1'b1;
                        r_o_rms    <= r_cur;
                        r_o_power  <= r_pw;
                        r_o_status <= r_stat;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_ovalid;
    assign o_rms_current = r_o_rms;
    assign o_power       = r_o_power;
    assign o_status      = r_o_status;

endmodule

`default_nettype wire

// ----- rtl/rcdb_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "rms_current_dc_blocked_unit_defines.svh"

module rcdb_chk (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_valid,
    input wire                              o_stall,
    input wire                              o_valid,
    input wire                              i_stall,
    input wire [rcdb_pkg::RMS_W-1:0]        o_rms_current,
    input wire [rcdb_pkg::POWER_W-1:0]      o_power,
    input wire                              o_status
);

    // Reset leaves no result on the output.
    `RCDB_ASSERT_NEXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !o_valid)

    // A result that is stalled keeps its fields.
    `RCDB_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_rms_current) && $stable(o_power) && $stable(o_status))

    // Every accepted request keeps the block busy in the following cycle.
    `RCDB_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

    // An aborted window reports zero current and zero power.
    `RCDB_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, o_valid && o_status, (o_rms_current == '0) && (o_power == '0))

endmodule

bind rms_current_dc_blocked_unit rcdb_chk u_rcdb_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_rms_current (o_rms_current),
    .o_power       (o_power),
    .o_status      (o_status)
);

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import rcdb_pkg::*;

    localparam int ADC_BITS      = 10;
    localparam int COUNT_BITS    = 16;
    localparam int ITEM_TARGET   = 650;
    localparam int SETTLE_CYCLES = 250;
    localparam int CYCLE_LIMIT   = 1500000;
    localparam longint FILT_MAX  = (longint'(1) << (ADC_BITS + 9)) - 1;
    localparam longint FILT_MIN  = -FILT_MAX - 1;

    typedef struct packed {
        logic [ADC_BITS-1:0] sample;
        logic                failed;
    } meter_sample_t;

    typedef struct packed {
        logic [RMS_W-1:0]   rms;
        logic [POWER_W-1:0] power;
        logic               status;
    } meter_reading_t;

    // Block ports.
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_valid       = 1'b0;
    logic                  o_stall;
    logic [ADC_BITS-1:0]   i_sample      = '0;
    logic                  i_read_failed = 1'b0;
    logic                  o_valid;
    logic                  i_stall       = 1'b0;
    logic [RMS_W-1:0]      o_rms_current;
    logic [POWER_W-1:0]    o_power;
    logic                  o_status;
    logic                  i_cfg_we      = 1'b0;
    t_cfg_idx              i_cfg_index   = CFG_FILTER_COEFF;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    // Pending requests and the readings they are owed.
    meter_sample_t  sample_backlog[$];
    meter_reading_t expected_readings[$];

    // Shadow of the meter: registers, filter memory, running energy and count.
    logic [COEFF_W-1:0]  m_coeff;
    logic [WLEN_W-1:0]   m_window;
    logic [GAIN_W-1:0]   m_gain;
    logic [VOLT_W-1:0]   m_volt;
    logic [ADC_BITS-1:0] m_last;
    longint              m_filt;
    logic [SUM_W-1:0]    m_energy;
    longint unsigned     m_count;

    // Run bookkeeping.
    bit steady        = 1'b0;
    int items_queued  = 0;
    int samples_sent  = 0;
    int readings_seen = 0;
    int aborts_seen   = 0;
    int settings_done = 0;
    int mismatches    = 0;
    int cycle_count   = 0;

    rms_current_dc_blocked_unit #(
        .ADC_BITS   (ADC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sample      (i_sample),
        .i_read_failed (i_read_failed),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_rms_current (o_rms_current),
        .o_power       (o_power),
        .o_status      (o_status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Floor of the square root, one bit at a time from the top.
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
        end
        return root;
    endfunction

    function automatic void meter_reset();
        m_coeff  = COEFF_RESET;
        m_window = WLEN_RESET;
        m_gain   = GAIN_RESET;
        m_volt   = VOLT_RESET;
        m_last   = '0;
        m_filt   = 0;
        m_energy = '0;
        m_count  = 0;
    endfunction

    function automatic void meter_config(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_FILTER_COEFF:  m_coeff  = data[COEFF_W-1:0];
            CFG_WINDOW_LENGTH: m_window = data[WLEN_W-1:0];
            CFG_CURRENT_GAIN:  m_gain   = data[GAIN_W-1:0];
            CFG_LINE_VOLTAGE:  m_volt   = data[VOLT_W-1:0];
            default: ;
        endcase
    endfunction

    // Advance the shadow meter by one request and queue the reading it owes, if any.
    function automatic void meter_step(input logic [ADC_BITS-1:0] x, input logic failed);
        longint          t;
        longint          p;
        longint          y;
        longint unsigned mag;
        longint unsigned r;
        longint unsigned n;
        longint unsigned wl;
        logic [63:0]     sq;
        logic [63:0]     mean;
        logic [63:0]     rms;
        logic [95:0]     scaled;
        logic [63:0]     watts;
        meter_reading_t  rd;

        // A failed read drops the window but leaves the filter alone.
        if (failed) begin
            m_energy  = '0;
            m_count   = 0;
            rd.rms    = '0;
            rd.power  = '0;
            rd.status = 1'b1;
            expected_readings.push_back(rd);
            return;
        end

        // High-pass step, rounded half away from zero, clamped to the filter width.
        t   = m_filt + (longint'(x) - longint'(m_last)) * 256;
        p   = t * longint'(m_coeff);
        mag = (p < 0) ? -p : p;
        r   = (mag + 64'd32768) >> 16;
        if (p < 0) y = (r > FILT_MAX + 1) ? FILT_MIN : -longint'(r);
        else       y = (r > FILT_MAX) ? FILT_MAX : longint'(r);
        m_last = x;
        m_filt = y;

        // Accumulate the square with saturation.
        mag      = (y < 0) ? -y : y;
        sq       = mag * mag;
        m_energy = (m_energy > ~sq) ? '1 : m_energy + sq;

        n  = m_count + 1;
        wl = (m_window == 0) ? 1 : m_window;
        if (n < wl && n < (longint'(1) << COUNT_BITS)) begin
            m_count = n;
            return;
        end

        // Window closed: mean, root, then gain and power, the last two saturating.
        mean = m_energy / n;
        if (mean < 64'h0001_0000_0000_0000) rms = int_sqrt(mean << 16);
        else                                rms = int_sqrt(mean) << 8;
        scaled    = {32'd0, rms} * {64'd0, m_gain};
        rd.rms    = (scaled[95:48] != 0) ? '1 : scaled[47:16];
        watts     = {32'd0, rd.rms} * {54'd0, m_volt};
        rd.power  = (watts[63:48] != 0) ? '1 : watts[47:0];
        rd.status = 1'b0;
        m_energy  = '0;
        m_count   = 0;
        expected_readings.push_back(rd);
    endfunction

    function automatic void queue_sample(input logic [ADC_BITS-1:0] x, input logic failed);
        meter_sample_t req;
        req.sample = x;
        req.failed = failed;
        sample_backlog.push_back(req);
        items_queued++;
    endfunction

    // Random samples with the rails now and then and an occasional failed read.
    function automatic void queue_random(input int count);
        logic [ADC_BITS-1:0] x;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(19))
                0:       x = '0;
                1:       x = '1;
                default: x = ADC_BITS'($urandom());
            endcase
            queue_sample(x, $urandom_range(24) == 0);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on reading %0d, %s: got 0x%0h, expected 0x%0h",
                 $time, readings_seen, what, got, want);
        mismatches++;
    endtask

    task automatic check_reading();
        meter_reading_t want;
        if (expected_readings.size() == 0) begin
            report_mismatch("reading with no request owed", o_rms_current, 64'd0);
            return;
        end
        want = expected_readings.pop_front();
        readings_seen++;
        if (want.status) aborts_seen++;
        if (o_rms_current !== want.rms) report_mismatch("rms_current", o_rms_current, want.rms);
        if (o_power !== want.power) report_mismatch("power", o_power, want.power);
        if (o_status !== want.status) report_mismatch("status", o_status, want.status);
    endtask

    // One register write per cycle; the caller lowers the write enable after a batch.
    task automatic load_register(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        meter_config(idx, data);
        settings_done++;
        @(posedge i_clk);
    endtask

    // Wait until every request is in and every reading is out, then let the block go quiet.
    task automatic settle();
        while (sample_backlog.size() != 0 || i_valid || expected_readings.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Request driver: predicts on acceptance, then offers the next request or idles.
    meter_sample_t next_req;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                meter_step(i_sample, i_read_failed);
                samples_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (sample_backlog.size() != 0 && (steady || $urandom_range(99) >= 29)) begin
                    next_req      = sample_backlog.pop_front();
                    i_valid       <= 1'b1;
                    i_sample      <= next_req.sample;
                    i_read_failed <= next_req.failed;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Reading monitor with random back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) check_reading();
            i_stall <= !steady && ($urandom_range(99) < 29);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("watchdog expired after %0d cycles", cycle_count);
            $display("rms_current_dc_blocked_unit regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        int                  phase;
        int                  wl_eff;
        int                  count;
        logic [WLEN_W-1:0]   wl;
        logic [COEFF_W-1:0]  coeff;
        logic [GAIN_W-1:0]   gain;

        phase = 0;
        meter_reset();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Coefficient, gain and voltage at their top values, junk above the narrow ones; one-sample windows.
        load_register(CFG_FILTER_COEFF, {16'hA5A5, 16'hFFFF});
        load_register(CFG_WINDOW_LENGTH, {16'h5A5A, 16'd1});
        load_register(CFG_CURRENT_GAIN, 32'hFFFF_FFFF);
        load_register(CFG_LINE_VOLTAGE, {22'h3F_FFFF, 10'd1023});
        i_cfg_we <= 1'b0;
        queue_sample(10'd1023, 1'b0);
        queue_sample(10'd0, 1'b0);
        queue_sample(10'd1023, 1'b0);
        queue_sample(10'd512, 1'b0);
        queue_sample(10'd1023, 1'b0);
        queue_sample(10'd1023, 1'b1);
        queue_sample(10'd0, 1'b0);

        // All registers at zero: a zero window length behaves as one.
        settle();
        load_register(CFG_FILTER_COEFF, 32'd0);
        load_register(CFG_WINDOW_LENGTH, 32'd0);
        load_register(CFG_CURRENT_GAIN, 32'd0);
        load_register(CFG_LINE_VOLTAGE, 32'd0);
        i_cfg_we <= 1'b0;
        queue_sample(10'd1023, 1'b0);
        queue_sample(10'd0, 1'b0);
        queue_sample(10'd0, 1'b1);

        // Default calibration, short windows, and a failed read in mid-window.
        settle();
        load_register(CFG_FILTER_COEFF, {16'd0, COEFF_RESET});
        load_register(CFG_WINDOW_LENGTH, 32'd3);
        load_register(CFG_CURRENT_GAIN, GAIN_RESET);
        load_register(CFG_LINE_VOLTAGE, {22'd0, VOLT_RESET});
        i_cfg_we <= 1'b0;
        queue_sample(10'd1023, 1'b0);
        queue_sample(10'd1023, 1'b0);
        queue_sample(10'd0, 1'b0);
        queue_sample(10'd700, 1'b0);
        queue_sample(10'd12, 1'b0);
        queue_sample(10'd555, 1'b1);
        queue_sample(10'd300, 1'b0);
        queue_sample(10'd301, 1'b0);
        queue_sample(10'd302, 1'b0);

        // Longest window, then shortened in mid-window so the next sample closes it.
        settle();
        load_register(CFG_FILTER_COEFF, 32'd32768);
        load_register(CFG_WINDOW_LENGTH, 32'd65535);
        i_cfg_we <= 1'b0;
        queue_random(5);
        settle();
        load_register(CFG_WINDOW_LENGTH, 32'd2);
        i_cfg_we <= 1'b0;
        queue_sample(10'd777, 1'b0);

        // Random phases; each may rewrite any register, and windows may span phases.
        while (items_queued < ITEM_TARGET) begin
            settle();
            phase++;
            steady = (phase == 3);
            if ($urandom_range(9) < 6) begin
                case ($urandom_range(9))
                    0:       coeff = '0;
                    1:       coeff = '1;
                    2:       coeff = COEFF_RESET;
                    3, 4:    coeff = COEFF_W'($urandom());
                    default: coeff = COEFF_W'($urandom_range(65535, 60000));
                endcase
                load_register(CFG_FILTER_COEFF, {16'($urandom()), coeff});
            end
            if ($urandom_range(9) < 6) begin
                case ($urandom_range(19))
                    0:       wl = '0;
                    1, 2:    wl = WLEN_W'($urandom_range(40, 9));
                    default: wl = WLEN_W'($urandom_range(6, 1));
                endcase
                load_register(CFG_WINDOW_LENGTH, {16'($urandom()), wl});
            end
            if ($urandom_range(9) < 5) begin
                case ($urandom_range(9))
                    0:       gain = '0;
                    1:       gain = '1;
                    2, 3:    gain = $urandom();
                    default: gain = GAIN_W'($urandom_range(200000));
                endcase
                load_register(CFG_CURRENT_GAIN, gain);
            end
            if ($urandom_range(9) < 4)
                load_register(CFG_LINE_VOLTAGE, $urandom());
            i_cfg_we <= 1'b0;
            wl_eff = (m_window == 0) ? 1 : m_window;
            if (wl_eff > 40) wl_eff = 40;
            count = steady ? 80 : $urandom_range(4 * wl_eff + 3, 3);
            queue_random(count);
        end

        settle();
        steady = 1'b0;
        $display("covered %0d requests over %0d register writes", samples_sent, settings_done);
        $display("checked %0d readings, %0d of them aborted windows", readings_seen, aborts_seen);
        if (mismatches == 0) begin
            $display("rms_current_dc_blocked_unit regression: pass");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("rms_current_dc_blocked_unit regression: fail");
        end
        $finish;
    end

endmodule
